>>> rtl/fpla_pkg.sv
package fpla_pkg;

  // ring and page geometry
  localparam int ItemsPerPage  = 252;
  localparam int HeaderBytes   = 16;
  localparam int FragmentBytes = 128;
  localparam int WordBytes     = 4;

  localparam int PageOffW  = 8;
  localparam int PageAbsW  = 9;
  localparam int SlotW     = 8;
  localparam int FragW     = 5;
  localparam int FragMapW  = 32;
  localparam int CountW    = 9;
  localparam int CfgDataW  = 9;
  localparam int CfgIndexW = 1;

  // byte offset of the end of an item plus rounding, and the fragment shift
  localparam int OffsetW   = $clog2(HeaderBytes + WordBytes * 256 + FragmentBytes);
  localparam int FragShift = $clog2(FragmentBytes);

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgFirstPage = 1'd0;
  localparam logic [CfgIndexW-1:0] CfgPageCount = 1'd1;

  typedef struct packed {
    logic [31:0] item_word;
    logic [31:0] sequence_number;
    logic        force_new_page;
  } item_t;

  typedef struct packed {
    logic [PageAbsW-1:0] page_index;
    logic [SlotW-1:0]    slot_index;
    logic [31:0]         write_word;
    logic                open_page;
    logic [31:0]         header_sequence;
    logic [PageAbsW-1:0] oldest_page_index;
    logic                mark_fragment;
    logic [FragW-1:0]    fragment_index;
  } result_t;

endpackage

>>> rtl/fpla_if.sv
interface fpla_item_if
  import fpla_pkg::*;
  (input logic clk);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fpla_result_if
  import fpla_pkg::*;
  (input logic clk);
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/flash_page_ring_log_allocator.sv
// channel   direction  payload                                 handshake
// items     sink       item_word, sequence_number, force_new   valid/ready
// results   source     page, slot, word, header, oldest, frag  valid/ready
// cfg       write      cfg_index selects first_page/page_count cfg_write
//
// one item per cycle unless a result stalls; each result is registered
// in the single result register behind the pointer and bitmap logic.
// rst (synchronous) clears the ring state and the result valid.
// a stalled result holds; a new item is taken in the same cycle the held
// result leaves; one transaction per cycle while results are ready.
module flash_page_ring_log_allocator
  import fpla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  fpla_item_if.sink            items,
  fpla_result_if.source        results
);

  logic [PageOffW-1:0] first_page;
  logic [CountW-1:0]   page_count;

  logic                log_started;
  logic [PageOffW-1:0] newest_page;
  logic [PageOffW-1:0] oldest_page;
  logic [SlotW-1:0]    next_slot;
  logic [FragMapW-1:0] used_fragment_map;

  logic [PageOffW-1:0] newest_page_next;
  logic [PageOffW-1:0] oldest_page_next;
  logic [SlotW-1:0]    next_slot_next;
  logic [FragMapW-1:0] used_fragment_map_next;

  logic    out_valid;
  result_t out_data;
  result_t result_next;
  logic    accept;

  logic                opening;
  logic [SlotW-1:0]    slot;
  logic [OffsetW-1:0]  offset;
  logic [OffsetW-1:0]  frag_full;
  logic [OffsetW-1:0]  frag;
  logic [FragMapW-1:0] map_open;
  logic                frag_in_map;
  logic                mark;

  // one step round the ring, wrapping at page_count or past 8 bits
  function automatic logic [PageOffW-1:0] ring_advance(
    input logic [PageOffW-1:0] off,
    input logic [CountW-1:0]   count
  );
    logic [CountW-1:0] nxt;
    nxt = {1'b0, off} + CountW'(1);
    if (nxt >= count || nxt[CountW-1]) begin
      return '0;
    end
    return nxt[PageOffW-1:0];
  endfunction

  assign accept        = items.valid && items.ready;
  assign items.ready   = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign results.payload = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= '0;
      page_count <= CountW'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgFirstPage: first_page <= cfg_data[PageOffW-1:0];
        CfgPageCount: page_count <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // page opening and ring pointer update
  always_comb begin
    opening = (next_slot == '0) || (next_slot >= SlotW'(ItemsPerPage))
              || items.payload.force_new_page;
    newest_page_next = newest_page;
    oldest_page_next = oldest_page;
    if (opening) begin
      if (!log_started) begin
        newest_page_next = '0;
        oldest_page_next = '0;
      end else begin
        newest_page_next = ring_advance(newest_page, page_count);
        if (newest_page_next == oldest_page) begin
          oldest_page_next = ring_advance(oldest_page, page_count);
        end
      end
    end
    slot           = opening ? '0 : next_slot;
    next_slot_next = slot + SlotW'(1);
    map_open       = opening ? FragMapW'(1) : used_fragment_map;
  end

  // fragment that holds the end of this item
  always_comb begin
    offset    = OffsetW'(HeaderBytes) + OffsetW'(WordBytes) * OffsetW'(next_slot_next);
    frag_full = (offset + OffsetW'(FragmentBytes - 1)) >> FragShift;
    frag      = (frag_full == '0) ? '0 : frag_full - OffsetW'(1);
    frag_in_map = frag < OffsetW'(FragMapW);
    mark = 1'b0;
    used_fragment_map_next = map_open;
    if (frag_in_map && !map_open[frag[FragW-1:0]]) begin
      mark = 1'b1;
      used_fragment_map_next[frag[FragW-1:0]] = 1'b1;
    end
  end

  // result fields
  always_comb begin
    result_next.page_index      = PageAbsW'(first_page) + PageAbsW'(newest_page_next);
    result_next.slot_index      = slot;
    result_next.write_word      = items.payload.item_word;
    result_next.open_page       = opening;
    result_next.header_sequence = opening ? items.payload.sequence_number : '0;
    result_next.oldest_page_index = PageAbsW'(first_page) + PageAbsW'(oldest_page_next);
    result_next.mark_fragment   = mark;
    result_next.fragment_index  = frag_in_map ? frag[FragW-1:0] : '1;
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      log_started       <= 1'b0;
      newest_page       <= '0;
      oldest_page       <= '0;
      next_slot         <= '0;
      used_fragment_map <= '0;
    end else if (accept) begin
      log_started       <= 1'b1;
      newest_page       <= newest_page_next;
      oldest_page       <= oldest_page_next;
      next_slot         <= next_slot_next;
      used_fragment_map <= used_fragment_map_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

endmodule

>>> rtl/fpla_checker.sv
module fpla_checker
  import fpla_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // a stalled result transaction holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an opened page always starts at slot zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.open_page |-> out_data.slot_index == '0)
    else $error("page opened at nonzero slot");

  // continuing a page never reuses slot zero and carries no header
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.open_page |->
      out_data.slot_index != '0 && out_data.header_sequence == '0)
    else $error("bad slot or header on continued page");

  // first item of a page ends in the header fragment, already used
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.open_page |-> !out_data.mark_fragment)
    else $error("fragment marked on page open");

endmodule

bind flash_page_ring_log_allocator fpla_checker u_fpla_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.payload)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fpla_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  fpla_item_if   items_ch (clk);
  fpla_result_if results_ch (clk);

  flash_page_ring_log_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .results   (results_ch)
  );

  // idle and stall percentages for the current phase
  int send_idle;
  int recv_stall;
  int mismatch_count;

  // mirror of the ring registers and the allocator state
  logic [PageOffW-1:0] ring_first;
  logic [CountW-1:0]   ring_size;
  logic                log_live;
  logic [PageOffW-1:0] head_off;
  logic [PageOffW-1:0] tail_off;
  logic [SlotW-1:0]    fill_slot;
  logic [FragMapW-1:0] frag_map;

  result_t pending_placements[$];

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // one step round the ring; empty and oversized rings fold in here
  function automatic logic [PageOffW-1:0] ring_next(logic [PageOffW-1:0] off);
    logic [CountW-1:0] nxt;
    nxt = {1'b0, off} + 9'd1;
    if (nxt >= ring_size || nxt > 9'd255)
      nxt = '0;
    return nxt[PageOffW-1:0];
  endfunction

  // flash location, header and fragment for one log word
  function automatic result_t predict_placement(item_t it);
    result_t r;
    logic    opening;
    int      offset;
    int      frag;
    opening = (fill_slot == '0) || (int'(fill_slot) >= ItemsPerPage) || it.force_new_page;
    if (opening) begin
      if (!log_live) begin
        log_live = 1'b1;
        head_off = '0;
        tail_off = '0;
      end else begin
        head_off = ring_next(head_off);
        if (head_off == tail_off)
          tail_off = ring_next(tail_off);
      end
      fill_slot = '0;
      frag_map  = 32'd1;
    end
    r.slot_index = fill_slot;
    fill_slot = fill_slot + 8'd1;
    // fragment holding the last byte of this word
    offset = HeaderBytes + WordBytes * int'(fill_slot);
    frag = (offset + FragmentBytes - 1) / FragmentBytes;
    if (frag > 0)
      frag = frag - 1;
    r.mark_fragment = 1'b0;
    if (frag < FragMapW) begin
      r.fragment_index = frag[FragW-1:0];
      if (!frag_map[frag]) begin
        frag_map[frag]  = 1'b1;
        r.mark_fragment = 1'b1;
      end
    end else begin
      r.fragment_index = 5'd31;
    end
    r.page_index        = {1'b0, ring_first} + {1'b0, head_off};
    r.oldest_page_index = {1'b0, ring_first} + {1'b0, tail_off};
    r.write_word        = it.item_word;
    r.open_page         = opening;
    r.header_sequence   = opening ? it.sequence_number : 32'd0;
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // result side: random ready, check each transaction against the oldest placement
  always @(posedge clk) begin : result_monitor
    result_t want;
    result_t got;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got = results_ch.payload;
      if (pending_placements.size() == 0) begin
        $display("%0t: unexpected result expected none actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_placements.pop_front();
        compare_field("page_index", want.page_index, got.page_index);
        compare_field("slot_index", want.slot_index, got.slot_index);
        compare_field("write_word", want.write_word, got.write_word);
        compare_field("open_page", want.open_page, got.open_page);
        compare_field("header_sequence", want.header_sequence, got.header_sequence);
        compare_field("oldest_page_index", want.oldest_page_index, got.oldest_page_index);
        compare_field("mark_fragment", want.mark_fragment, got.mark_fragment);
        compare_field("fragment_index", want.fragment_index, got.fragment_index);
      end
    end
    results_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // item side: optional gap, then hold valid until the transaction
  task automatic send_item(item_t it);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      items_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    items_ch.valid   <= 1'b1;
    items_ch.payload <= it;
    do @(posedge clk); while (!items_ch.ready);
    pending_placements.push_back(predict_placement(it));
  endtask

  // write both ring registers once the block has drained
  task automatic set_ring(logic [CfgDataW-1:0] first, logic [CfgDataW-1:0] count);
    items_ch.valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CfgFirstPage;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= CfgPageCount;
    cfg_data  <= count;
    @(posedge clk);
    cfg_write  <= 1'b0;
    ring_first = first[PageOffW-1:0];
    ring_size  = count;
  endtask

  function automatic item_t make_item(int force_pct);
    item_t it;
    case ($urandom_range(7))
      0:       it.item_word = 32'h0000_0000;
      1:       it.item_word = 32'hFFFF_FFFF;
      default: it.item_word = $urandom;
    endcase
    it.sequence_number = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
    it.force_new_page  = ($urandom_range(99) < force_pct);
    return it;
  endfunction

  function automatic item_t fixed_item(logic [31:0] word, logic [31:0] seq, logic force_bit);
    item_t it;
    it.item_word       = word;
    it.sequence_number = seq;
    it.force_new_page  = force_bit;
    return it;
  endfunction

  function automatic logic [CfgDataW-1:0] random_first();
    case ($urandom_range(3))
      0:       return 9'd0;
      1:       return 9'd255;
      default: return CfgDataW'($urandom_range(511));
    endcase
  endfunction

  // mostly small rings so the oldest page gets overtaken often
  function automatic logic [CfgDataW-1:0] random_count();
    case ($urandom_range(9))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return CfgDataW'($urandom_range(511, 257));
      3:       return CfgDataW'($urandom_range(511));
      default: return CfgDataW'($urandom_range(8, 1));
    endcase
  endfunction

  // reset ring, first page opened, extremes of the word and sequence
  task automatic test_reset_ring();
    send_item(fixed_item(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
    send_item(fixed_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
    send_item(fixed_item(32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1));
  endtask

  // ring bounds: full, empty, oversized, two pages, moved
  task automatic test_ring_bounds();
    set_ring(9'd255, 9'd256);
    repeat (3) send_item(fixed_item($urandom, $urandom, 1'b1));
    set_ring(9'd0, 9'd0);
    repeat (3) send_item(fixed_item($urandom, $urandom, 1'b1));
    set_ring(9'h1FF, 9'd511);
    repeat (2) send_item(fixed_item($urandom, $urandom, 1'b1));
    set_ring(9'd128, 9'd2);
    repeat (4) send_item(fixed_item($urandom, $urandom, 1'b1));
    // same ring, different start page
    set_ring(9'd3, 9'd2);
    send_item(fixed_item($urandom, $urandom, 1'b0));
    send_item(fixed_item($urandom, $urandom, 1'b1));
  endtask

  // fill one page to the end so the next word opens a page on its own
  task automatic test_page_fill();
    set_ring(random_first(), 9'd4);
    send_item(make_item(100));
    repeat (ItemsPerPage + 2) send_item(make_item(0));
  endtask

  // walk a full ring of forced pages past its wrap
  task automatic test_ring_wrap();
    set_ring(random_first(),
             ($urandom_range(1)) ? 9'd256 : CfgDataW'($urandom_range(511, 257)));
    repeat (258) send_item(make_item(100));
  endtask

  // random rings and force rates under every idle pattern
  task automatic test_random_traffic();
    int pct;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      for (int batch = 0; batch < 2; batch++) begin
        set_ring(random_first(), random_count());
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 3;
          2:       pct = 20;
          default: pct = 100;
        endcase
        repeat (5) send_item(make_item(pct));
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    send_idle      = 0;
    recv_stall     = 0;
    ring_first     = '0;
    ring_size      = 9'd1;
    log_live       = 1'b0;
    head_off       = '0;
    tail_off       = '0;
    fill_slot      = '0;
    frag_map       = '0;
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= CfgFirstPage;
    cfg_data         <= '0;
    items_ch.valid   <= 1'b0;
    items_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_ring();
    test_ring_bounds();
    send_idle = 85;
    recv_stall = 0;
    test_page_fill();
    send_idle = 0;
    recv_stall = 85;
    test_ring_wrap();
    test_random_traffic();

    // drain
    items_ch.valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_placements.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
